@@ sv/sg3_pkg.sv @@
// ----------------------------------------------------------------------------
// sg3_pkg: shared types and constants for the 3D Sobel gradient block
// Register indexes, default sizes, field widths and the voxel tag word.
// ----------------------------------------------------------------------------
package sg3_pkg;

	localparam int DEF_MAX_SIZE_X = 256;
	localparam int DEF_MAX_SIZE_Y = 256;
	localparam int DEF_MAX_SIZE_Z = 1024;
	localparam int DEF_VOXEL_BITS = 16;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SIZE_X  = 3'd0,
		REG_SIZE_Y  = 3'd1,
		REG_SIZE_Z  = 3'd2,
		REG_RECIP_X = 3'd3,
		REG_RECIP_Y = 3'd4,
		REG_RECIP_Z = 3'd5
	} reg_idx_t;

	localparam logic [8:0]  RST_SIZE_X = 9'd256;
	localparam logic [8:0]  RST_SIZE_Y = 9'd256;
	localparam logic [10:0] RST_SIZE_Z = 11'd1024;
	localparam logic [15:0] RST_RECIP  = 16'd256;

	localparam int CX_BITS = 8;
	localparam int CY_BITS = 8;
	localparam int CZ_BITS = 10;
	localparam int GRAD_BITS = 32;

	// side information that travels with a voxel through the pipeline
	typedef struct packed {
		logic                 hit;
		logic [CX_BITS-1:0]   cx;
		logic [CY_BITS-1:0]   cy;
		logic [CZ_BITS-1:0]   cz;
		logic                 last;
	} tag_t;

endpackage

@@ sv/sg3_cell.sv @@
// ----------------------------------------------------------------------------
// sg3_cell: one column cell of the 3x3 sliding window
// Holds nine column values (one 3x3 y/z slice at one x offset) and
// forwards them to its neighbor each accepted word; reduces its slice into
// the partial sums the axis filters need.
// ----------------------------------------------------------------------------
module sg3_cell
	import sg3_pkg::*;
#(
	parameter int VOXEL_BITS = DEF_VOXEL_BITS
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [9*VOXEL_BITS-1:0] col_in,   // 3x3 slice, index dz*3+dy
	output logic [9*VOXEL_BITS-1:0] col_out,
	output logic signed [VOXEL_BITS+5:0] smooth, // 1/2/4 weighted slice sum
	output logic signed [VOXEL_BITS+5:0] dy_sum, // y derivative over slice
	output logic signed [VOXEL_BITS+5:0] dz_sum  // z derivative over slice
);
	localparam int W = VOXEL_BITS + 6;

	logic [9*VOXEL_BITS-1:0] col_q;
	logic signed [W-1:0] v [9];

	// advance the slice on an accepted word
	always_ff @(posedge clk) begin
		if (en) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

	// weights: center of each perpendicular axis counts double
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			v[i] = W'(col_q[i*VOXEL_BITS +: VOXEL_BITS]);
		end
		smooth = v[0] + (v[1] <<< 1) + v[2] + (v[3] <<< 1) + (v[4] <<< 2)
		       + (v[5] <<< 1) + v[6] + (v[7] <<< 1) + v[8];
		dy_sum = (v[2] + (v[5] <<< 1) + v[8]) - (v[0] + (v[3] <<< 1) + v[6]);
		dz_sum = (v[6] + (v[7] <<< 1) + v[8]) - (v[0] + (v[1] <<< 1) + v[2]);
	end
endmodule

@@ sv/sg3_scale.sv @@
// ----------------------------------------------------------------------------
// sg3_scale: axis scaler
// Negates an axis sum, multiplies by the reciprocal spacing and floors the
// quotient by 32; one register after the multiply.
// ----------------------------------------------------------------------------
module sg3_scale
	import sg3_pkg::*;
#(
	parameter int SW = 24
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [SW-1:0]        sum,
	input  logic [15:0]                 recip,
	output logic signed [GRAD_BITS-1:0] grad
);
	logic signed [SW+17:0] prod_q;

	// multiply; arithmetic shift right by 5 is floor division by 32
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= -((SW+18)'(sum)) * $signed({2'b00, recip});
		end
	end

	logic signed [SW+17:0] shr;
	assign shr  = prod_q >>> 5;
	assign grad = shr[GRAD_BITS-1:0];
endmodule

@@ sv/sobel_gradient_3d.sv @@
// ----------------------------------------------------------------------------
// sobel_gradient_3d: streaming 3x3x3 Sobel gradient over a voxel volume
//
//   channel | dir | word
//   s_axis  | in  | tdata = voxel[15:0]; tuser = volume_start
//   m_axis  | out | tdata = grad_x, grad_y, grad_z, cx, cy, cz; tlast = final
//   cfg     | in  | cfg_we, cfg_idx, cfg_data (write only)
//
// One voxel per cycle sustained while m_axis does not stall. The plane memory
// and the row memory are each read once and written once per word, so no
// word needs a second pass. Four register stages: history read, column cells,
// axis sums and scale. The whole pipeline advances only when the output
// register can take a word, so stalls at m_axis hold every stage. Reset
// clears counters and valids.
// ----------------------------------------------------------------------------
module sobel_gradient_3d
	import sg3_pkg::*;
#(
	parameter int MAX_SIZE_X = DEF_MAX_SIZE_X,
	parameter int MAX_SIZE_Y = DEF_MAX_SIZE_Y,
	parameter int MAX_SIZE_Z = DEF_MAX_SIZE_Z,
	parameter int VOXEL_BITS = DEF_VOXEL_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [15:0]              s_axis_tdata,   // voxel
	input  logic                     s_axis_tuser,   // volume_start
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// grad_x[31:0], grad_y[63:32], grad_z[95:64], center_x[103:96],
	// center_y[111:104], center_z[121:112], zero fill to 128
	output logic [127:0]             m_axis_tdata,
	output logic                     m_axis_tlast,   // final_interior
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);
	localparam int XB = $clog2(MAX_SIZE_X + 1);
	localparam int YB = $clog2(MAX_SIZE_Y + 1);
	localparam int ZB = $clog2(MAX_SIZE_Z + 1);
	localparam int PX = $clog2(MAX_SIZE_X);
	localparam int PY = $clog2(MAX_SIZE_Y);
	localparam int PZ = $clog2(MAX_SIZE_Z);
	localparam int XA = (PX < 1) ? 1 : PX;
	localparam int SW = VOXEL_BITS + 8;
	localparam int VB = VOXEL_BITS;

	// configuration registers
	logic [8:0]  size_x_q, size_y_q;
	logic [10:0] size_z_q;
	logic [15:0] rx_q, ry_q, rz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= RST_SIZE_X;
			size_y_q <= RST_SIZE_Y;
			size_z_q <= RST_SIZE_Z;
			rx_q <= RST_RECIP;
			ry_q <= RST_RECIP;
			rz_q <= RST_RECIP;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SIZE_X:  size_x_q <= cfg_data[8:0];
				REG_SIZE_Y:  size_y_q <= cfg_data[8:0];
				REG_SIZE_Z:  size_z_q <= cfg_data[10:0];
				REG_RECIP_X: rx_q <= cfg_data;
				REG_RECIP_Y: ry_q <= cfg_data;
				REG_RECIP_Z: rz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp sizes into 3..max
	logic [XB-1:0] sx;
	logic [YB-1:0] sy;
	logic [ZB-1:0] sz;
	always_comb begin
		if (size_x_q < 9'd3) sx = XB'(3);
		else if (32'(size_x_q) > MAX_SIZE_X) sx = XB'(MAX_SIZE_X);
		else sx = XB'(size_x_q);
		if (size_y_q < 9'd3) sy = YB'(3);
		else if (32'(size_y_q) > MAX_SIZE_Y) sy = YB'(MAX_SIZE_Y);
		else sy = YB'(size_y_q);
		if (size_z_q < 11'd3) sz = ZB'(3);
		else if (32'(size_z_q) > MAX_SIZE_Z) sz = ZB'(MAX_SIZE_Z);
		else sz = ZB'(size_z_q);
	end

	// pipeline advance: everything moves when the output register is free
	logic adv, acc;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign acc = s_axis_tvalid && adv;

	// position counters
	logic [PX-1:0] px_q;
	logic [PY-1:0] py_q;
	logic [PZ-1:0] pz_q;
	logic [PX-1:0] x;
	logic [PY-1:0] y;
	logic [PZ-1:0] z;
	assign x = s_axis_tuser ? '0 : px_q;
	assign y = s_axis_tuser ? '0 : py_q;
	assign z = s_axis_tuser ? '0 : pz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
			pz_q <= '0;
		end else if (acc) begin
			if (32'(x) + 1 >= 32'(sx)) begin
				px_q <= '0;
				if (32'(y) + 1 >= 32'(sy)) begin
					py_q <= '0;
					pz_q <= (32'(z) + 1 >= 32'(sz)) ? '0 : PZ'(32'(z) + 1);
				end else begin
					py_q <= PY'(32'(y) + 1);
				end
			end else begin
				px_q <= PX'(32'(x) + 1);
			end
		end
	end

	// column memory: per (y,x), the last 9 values in y/z (3 planes x 3 rows)
	// rows memory keeps two rows for the current plane and three for each of
	// the previous two planes; stored as one 8-voxel word per address
	localparam int MW = 8 * VB;
	localparam int RA = PY + XA;
	// address: plane history is per (y,x); word holds rows y-1,y-2 of plane z
	// and rows y,y-1,y-2 of planes z-1,z-2 minus current voxel
	logic [MW-1:0] pmem [2**RA];
	logic [MW-1:0] rd_s1;
	logic [VB-1:0] vox_s1;
	tag_t          tag_s1;
	logic          v_s1;
	logic [RA-1:0] wa_s1;

	// tag of the window center for this voxel
	tag_t tag_in;
	always_comb begin
		tag_in.hit = (32'(x) >= 2) && (32'(y) >= 2) && (32'(z) >= 2)
		          && (32'(x) < 32'(sx)) && (32'(y) < 32'(sy)) && (32'(z) < 32'(sz));
		tag_in.cx = CX_BITS'(32'(x) - 1);
		tag_in.cy = CY_BITS'(32'(y) - 1);
		tag_in.cz = CZ_BITS'(32'(z) - 1);
		tag_in.last = (32'(x) == 32'(sx) - 1) && (32'(y) == 32'(sy) - 1)
		           && (32'(z) == 32'(sz) - 1);
	end

	logic [RA-1:0] ra;
	assign ra = {PY'(y), XA'(x)};

	// stage 1: read the history column at (y,x)
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s1  <= pmem[ra];
			vox_s1 <= s_axis_tdata[VB-1:0];
			tag_s1 <= tag_in;
			wa_s1  <= ra;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= acc;
	end

	// build 9-voxel column; word slots: [0]=(z,y-2) [1]=(z,y-1)
	// [2]=(z-1,y-2) [3]=(z-1,y-1) [4]=(z-1,y) [5]=(z-2,y-2) [6]=(z-2,y-1)
	// [7]=(z-2,y)
	logic [9*VB-1:0] col;
	logic [MW-1:0]   wr_word;
	always_comb begin
		// cell index dz*3+dy, dz/dy offsets 0..2 with 0 = oldest
		col[0*VB +: VB] = rd_s1[5*VB +: VB];
		col[1*VB +: VB] = rd_s1[6*VB +: VB];
		col[2*VB +: VB] = rd_s1[7*VB +: VB];
		col[3*VB +: VB] = rd_s1[2*VB +: VB];
		col[4*VB +: VB] = rd_s1[3*VB +: VB];
		col[5*VB +: VB] = rd_s1[4*VB +: VB];
		col[6*VB +: VB] = rd_s1[0*VB +: VB];
		col[7*VB +: VB] = rd_s1[1*VB +: VB];
		col[8*VB +: VB] = vox_s1;
		// shift for the next visit of this (y,x): next y, or next plane
		wr_word = rd_s1; // default keeps everything
		wr_word[0*VB +: VB] = rd_s1[1*VB +: VB];
		wr_word[1*VB +: VB] = vox_s1;
		wr_word[2*VB +: VB] = rd_s1[3*VB +: VB];
		wr_word[3*VB +: VB] = rd_s1[4*VB +: VB];
		wr_word[5*VB +: VB] = rd_s1[6*VB +: VB];
		wr_word[6*VB +: VB] = rd_s1[7*VB +: VB];
	end

	// The per-(y,x) word cannot carry y history since each (y,x) is visited
	// once per plane; keep rows in a per-x word and planes per (y,x).
	// Plane part: slots 2..7 of pmem; row part: separate memory by x.
	logic [3*VB-1:0] rmem [2**XA];
	logic [3*VB-1:0] rrd_s1;
	logic [XA-1:0]   rwa_s1;
	// rmem slots per x: [0]=(z,y-2) [1]=(z,y-1)
	always_ff @(posedge clk) begin
		if (adv) begin
			rrd_s1 <= rmem[XA'(x)];
			rwa_s1 <= XA'(x);
		end
	end

	// writes happen when the stage-1 word is valid and advancing
	logic [9*VB-1:0] colf;
	logic [MW-1:0]   pw;
	always_comb begin
		colf = col;
		colf[6*VB +: VB] = rrd_s1[0*VB +: VB];
		colf[7*VB +: VB] = rrd_s1[1*VB +: VB];
		// plane word for (y,x): planes z-1 rows y-2,y-1,y become z-2, and the
		// current rows become z-1
		pw = wr_word;
		pw[5*VB +: VB] = rd_s1[2*VB +: VB];
		pw[6*VB +: VB] = rd_s1[3*VB +: VB];
		pw[7*VB +: VB] = rd_s1[4*VB +: VB];
		pw[2*VB +: VB] = rrd_s1[0*VB +: VB];
		pw[3*VB +: VB] = rrd_s1[1*VB +: VB];
		pw[4*VB +: VB] = vox_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv) begin
			pmem[wa_s1] <= pw;
			rmem[rwa_s1] <= {vox_s1, vox_s1, rrd_s1[1*VB +: VB]};
		end
	end

	// chain of three column cells along x
	logic [9*VB-1:0] c0, c1, c2;
	logic signed [VB+5:0] sm [3];
	logic signed [VB+5:0] dy [3];
	logic signed [VB+5:0] dz [3];
	logic en_c;
	assign en_c = v_s1 && adv;

	sg3_cell #(.VOXEL_BITS(VB)) u_c0 (.clk(clk), .en(en_c), .col_in(colf),
		.col_out(c0), .smooth(sm[0]), .dy_sum(dy[0]), .dz_sum(dz[0]));
	sg3_cell #(.VOXEL_BITS(VB)) u_c1 (.clk(clk), .en(en_c), .col_in(c0),
		.col_out(c1), .smooth(sm[1]), .dy_sum(dy[1]), .dz_sum(dz[1]));
	sg3_cell #(.VOXEL_BITS(VB)) u_c2 (.clk(clk), .en(en_c), .col_in(c1),
		.col_out(c2), .smooth(sm[2]), .dy_sum(dy[2]), .dz_sum(dz[2]));

	// c2 is unused beyond its reduction; newest column is cell 0 (dx=+1)
	tag_t tag_s2;
	logic v_s2;
	always_ff @(posedge clk) begin
		if (adv) tag_s2 <= tag_s1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1 && tag_s1.hit;
	end

	// stage 3: axis sums
	logic signed [SW-1:0] gx_s3, gy_s3, gz_s3;
	tag_t tag_s3;
	logic v_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			gx_s3 <= SW'(sm[0]) - SW'(sm[2]);
			gy_s3 <= SW'(dy[0]) + (SW'(dy[1]) <<< 1) + SW'(dy[2]);
			gz_s3 <= SW'(dz[0]) + (SW'(dz[1]) <<< 1) + SW'(dz[2]);
			tag_s3 <= tag_s2;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	// stage 4: scale
	logic signed [GRAD_BITS-1:0] ox, oy, oz;
	sg3_scale #(.SW(SW)) u_sx (.clk(clk), .en(adv), .sum(gx_s3), .recip(rx_q), .grad(ox));
	sg3_scale #(.SW(SW)) u_sy (.clk(clk), .en(adv), .sum(gy_s3), .recip(ry_q), .grad(oy));
	sg3_scale #(.SW(SW)) u_sz (.clk(clk), .en(adv), .sum(gz_s3), .recip(rz_q), .grad(oz));

	tag_t tag_s4;
	always_ff @(posedge clk) begin
		if (adv) tag_s4 <= tag_s3;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (adv) m_axis_tvalid <= v_s3;
	end

	assign m_axis_tdata = {6'd0, tag_s4.cz, tag_s4.cy, tag_s4.cx, oz, oy, ox};
	assign m_axis_tlast = tag_s4.last;
endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sobel_gradient_3d
// Streams small voxel volumes through the block, predicts each gradient word
// from a local voxel history, and checks every output word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
	import sg3_pkg::*;
();

	localparam int HIST_DEPTH = 2 * 256 * 256 + 2 * 256 + 3;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic        start;
		logic [15:0] voxel;
	} voxel_word_t;

	typedef struct {
		logic [31:0] gx, gy, gz;
		logic [7:0]  cx, cy;
		logic [9:0]  cz;
		logic        last;
	} grad_word_t;

	logic                     clk = 0;
	logic                     arst_n = 0;
	logic                     s_axis_tvalid = 0;
	logic                     s_axis_tready;
	logic [15:0]              s_axis_tdata = '0;
	logic                     s_axis_tuser = 0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 0;
	logic [127:0]             m_axis_tdata;
	logic                     m_axis_tlast;
	logic                     cfg_we = 0;
	logic [CFG_IDX_BITS-1:0]  cfg_idx = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	sobel_gradient_3d DUT (.*);

	always #4 clk = ~clk;

	// predictor state
	logic [15:0] voxel_hist [HIST_DEPTH];
	int unsigned hist_ptr, px, py, pz;
	int unsigned dim_x, dim_y, dim_z, rsx, rsy, rsz;

	voxel_word_t pending_voxels [$];
	grad_word_t  expected_grads [$];
	int errors = 0, words_checked = 0, voxels_sent = 0;
	int hold_off = 0;
	longint cycles = 0;

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		return v < 3 ? 3 : (v > hi ? hi : v);
	endfunction

	function automatic logic [31:0] scale_grad(longint s, int unsigned r);
		longint n, q;
		n = -s * longint'(r);
		q = n >= 0 ? n / 32 : -((-n + 31) / 32);
		return q[31:0];
	endfunction

	// advance the predictor by one accepted voxel
	task automatic predict_voxel(voxel_word_t w);
		int unsigned sx, sy, sz, x, y, z, d, idx;
		longint gx, gy, gz, v, wx, wy, wz;
		grad_word_t g;
		sx = clamp_dim(dim_x, 256);
		sy = clamp_dim(dim_y, 256);
		sz = clamp_dim(dim_z, 1024);
		if (w.start) begin
			px = 0; py = 0; pz = 0;
		end
		x = px; y = py; z = pz;
		voxel_hist[hist_ptr] = w.voxel;
		hist_ptr = (hist_ptr + 1 == HIST_DEPTH) ? 0 : hist_ptr + 1;
		if (x >= 2 && y >= 2 && z >= 2 && x < sx && y < sy && z < sz) begin
			gx = 0; gy = 0; gz = 0;
			for (int dz = -1; dz <= 1; dz++)
				for (int dy = -1; dy <= 1; dy++)
					for (int dx = -1; dx <= 1; dx++) begin
						d = (1 - dx) + (1 - dy) * sx + (1 - dz) * sx * sy;
						idx = (hist_ptr + HIST_DEPTH - 1 - d) % HIST_DEPTH;
						v = voxel_hist[idx];
						wx = (dy == 0 ? 2 : 1) * (dz == 0 ? 2 : 1);
						wy = (dx == 0 ? 2 : 1) * (dz == 0 ? 2 : 1);
						wz = (dx == 0 ? 2 : 1) * (dy == 0 ? 2 : 1);
						gx += v * dx * wx;
						gy += v * dy * wy;
						gz += v * dz * wz;
					end
			g.gx = scale_grad(gx, rsx);
			g.gy = scale_grad(gy, rsy);
			g.gz = scale_grad(gz, rsz);
			g.cx = 8'(x - 1);
			g.cy = 8'(y - 1);
			g.cz = 10'(z - 1);
			g.last = (x == sx - 1 && y == sy - 1 && z == sz - 1);
			expected_grads.push_back(g);
		end
		if (x + 1 >= sx) begin
			px = 0;
			if (y + 1 >= sy) begin
				py = 0;
				pz = (z + 1 >= sz) ? 0 : z + 1;
			end else
				py = y + 1;
		end else
			px = x + 1;
	endtask

	// handshake flags latched at the rising edge, acted on at the falling edge
	logic in_fire = 0;
	logic out_fire = 0;
	always @(posedge clk) begin
		in_fire  <= s_axis_tvalid && s_axis_tready;
		out_fire <= m_axis_tvalid && m_axis_tready;
	end

	// driver: offer queued voxels with random gaps
	int src_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire) begin
				predict_voxel('{s_axis_tuser, s_axis_tdata});
				voxels_sent++;
				pending_voxels.pop_front();
				src_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
			end
			if (src_gap > 0) begin
				src_gap--;
				s_axis_tvalid <= 0;
			end else if (pending_voxels.size() > 0) begin
				s_axis_tvalid <= 1;
				s_axis_tdata  <= pending_voxels[0].voxel;
				s_axis_tuser  <= pending_voxels[0].start;
			end else
				s_axis_tvalid <= 0;
		end
	end

	// sink: random stalls, plus a long hold-off on request
	int sink_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off > 0) begin
				hold_off--;
				m_axis_tready <= 0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= 1;
				if (out_fire)
					sink_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
			end
		end
	end

	// monitor: compare each output word with the oldest prediction
	always @(posedge clk) begin
		grad_word_t e;
		cycles++;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_grads.size() == 0) begin
				$error("unexpected output word");
				errors++;
			end else begin
				e = expected_grads.pop_front();
				words_checked++;
				if (m_axis_tdata[31:0] !== e.gx) begin
					$error("grad_x exp %0d got %0d", $signed(e.gx),
						$signed(m_axis_tdata[31:0]));
					errors++;
				end
				if (m_axis_tdata[63:32] !== e.gy) begin
					$error("grad_y exp %0d got %0d", $signed(e.gy),
						$signed(m_axis_tdata[63:32]));
					errors++;
				end
				if (m_axis_tdata[95:64] !== e.gz) begin
					$error("grad_z exp %0d got %0d", $signed(e.gz),
						$signed(m_axis_tdata[95:64]));
					errors++;
				end
				if (m_axis_tdata[103:96] !== e.cx) begin
					$error("center_x exp %0d got %0d", e.cx, m_axis_tdata[103:96]);
					errors++;
				end
				if (m_axis_tdata[111:104] !== e.cy) begin
					$error("center_y exp %0d got %0d", e.cy, m_axis_tdata[111:104]);
					errors++;
				end
				if (m_axis_tdata[121:112] !== e.cz) begin
					$error("center_z exp %0d got %0d", e.cz, m_axis_tdata[121:112]);
					errors++;
				end
				if (m_axis_tlast !== e.last) begin
					$error("final_interior exp %0d got %0d", e.last, m_axis_tlast);
					errors++;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// write one register at the falling edge; mirror it in the predictor
	task automatic write_reg(reg_idx_t idx, int unsigned value);
		@(negedge clk);
		cfg_we   <= 1;
		cfg_idx  <= idx;
		cfg_data <= value[15:0];
		case (idx)
			REG_SIZE_X:  dim_x = value & 'h1FF;
			REG_SIZE_Y:  dim_y = value & 'h1FF;
			REG_SIZE_Z:  dim_z = value & 'h7FF;
			REG_RECIP_X: rsx = value & 'hFFFF;
			REG_RECIP_Y: rsy = value & 'hFFFF;
			REG_RECIP_Z: rsz = value & 'hFFFF;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain;
		while (pending_voxels.size() > 0 || expected_grads.size() > 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_voxel(int mode);
		case (mode)
			0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			1: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, 3)) << $urandom_range(0, 14);
		endcase
	endfunction

	// queue one whole volume, first voxel flagged as start if flag_start is set
	task automatic queue_volume(int unsigned nx, int unsigned ny, int unsigned nz,
		int mode, bit flag_start);
		int unsigned n;
		n = nx * ny * nz;
		for (int unsigned i = 0; i < n; i++)
			pending_voxels.push_back('{flag_start && i == 0, pick_voxel(mode)});
	endtask

	initial begin
		int unsigned nx, ny, nz;
		hist_ptr = 0; px = 0; py = 0; pz = 0;
		dim_x = RST_SIZE_X; dim_y = RST_SIZE_Y; dim_z = RST_SIZE_Z;
		rsx = RST_RECIP; rsy = RST_RECIP; rsz = RST_RECIP;
		foreach (voxel_hist[i]) voxel_hist[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: smallest cube, extreme voxels and extreme spacings
		write_reg(REG_SIZE_X, 3);
		write_reg(REG_SIZE_Y, 3);
		write_reg(REG_SIZE_Z, 3);
		write_reg(REG_RECIP_X, 16'hFFFF);
		write_reg(REG_RECIP_Y, 0);
		write_reg(REG_RECIP_Z, 1);
		for (int i = 0; i < 27; i++)
			pending_voxels.push_back('{i == 0, (i % 2) ? 16'hFFFF : 16'h0000});
		drain();

		// sizes below the minimum act as three; volume without a start flag
		write_reg(REG_SIZE_X, 0);
		write_reg(REG_SIZE_Y, 2);
		write_reg(REG_SIZE_Z, 1);
		write_reg(REG_RECIP_X, 256);
		write_reg(REG_RECIP_Y, 16'hFFFF);
		write_reg(REG_RECIP_Z, 16'hFFFF);
		queue_volume(3, 3, 3, 0, 0);
		drain();

		// long hold-off at the sink while the source keeps offering
		write_reg(REG_SIZE_X, 5);
		write_reg(REG_SIZE_Y, 4);
		write_reg(REG_SIZE_Z, 4);
		queue_volume(5, 4, 4, 1, 1);
		hold_off = 300;
		drain();

		// random volumes with random spacings
		while (voxels_sent < 1250) begin
			nx = $urandom_range(3, 8);
			ny = $urandom_range(3, 6);
			nz = $urandom_range(3, 5);
			write_reg(REG_SIZE_X, nx);
			write_reg(REG_SIZE_Y, ny);
			write_reg(REG_SIZE_Z, nz);
			write_reg(REG_RECIP_X, $urandom_range(0, 3) == 0 ? 16'hFFFF
				: $urandom_range(0, 65535));
			write_reg(REG_RECIP_Y, $urandom_range(0, 65535));
			write_reg(REG_RECIP_Z, $urandom_range(0, 3) == 0 ? 0
				: $urandom_range(0, 65535));
			queue_volume(nx, ny, nz, $urandom_range(0, 2), $urandom_range(0, 4) != 0);
			if ($urandom_range(0, 2) == 0)
				queue_volume(nx, ny, nz, $urandom_range(0, 2), 1);
			drain();
		end

		$display("covered %0d voxels and %0d gradient words over many volume shapes",
			voxels_sent, words_checked);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

@@ sobel_gradient_3d.f @@
sv/sg3_pkg.sv
sv/sg3_cell.sv
sv/sg3_scale.sv
sv/sobel_gradient_3d.sv
tb/testbench.sv
